[hdl/i2c_register_access_master_macros.svh]
// assertion macros shared by the i2c register access master
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define I2CRAM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CRAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/i2cram_pkg.sv]
// types and constants of the i2c register access master
`timescale 1ns / 1ps

package i2cram_pkg;

   localparam int SLOT_W = 7;

   // item kinds on the request channel
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_CMD  = 1'b1;

   // transaction lengths in bus slots
   localparam logic [SLOT_W-1:0] WRITE_SLOTS = 7'd58;
   localparam logic [SLOT_W-1:0] READ_SLOTS  = 7'd78;

   // slot map landmarks
   localparam logic [SLOT_W-1:0] DEV_BYTE_START   = 7'd2;
   localparam logic [SLOT_W-1:0] REG_BYTE_START   = 7'd20;
   localparam logic [SLOT_W-1:0] THIRD_PART_START = 7'd38;
   localparam logic [SLOT_W-1:0] WR_STOP_START    = 7'd56;
   localparam logic [SLOT_W-1:0] RD_ADDR_START    = 7'd40;
   localparam logic [SLOT_W-1:0] RD_DATA_START    = 7'd58;
   localparam logic [SLOT_W-1:0] RD_NAK_HIGH      = 7'd74;
   localparam logic [SLOT_W-1:0] RD_NAK_LOW       = 7'd75;
   localparam logic [SLOT_W-1:0] RD_STOP_LOW      = 7'd76;

   // bus levels for one slot plus the receive strobe
   typedef struct packed {
      logic scl;
      logic sda;
      logic rx;
   } slot_lines_type;

endpackage

[hdl/i2cram_slot_decode.sv]
// slot map decoder: bus levels for one slot of a transaction
`timescale 1ns / 1ps

module i2cram_slot_decode
   import i2cram_pkg::*;
(
   input  logic [SLOT_W-1:0] slot,
   input  logic              is_read,
   input  logic [7:0]        device_address,
   input  logic [7:0]        register_address,
   input  logic [7:0]        write_data,
   output slot_lines_type    lines
);

   logic [7:0] read_device_address;

   // sixteen data slots (high then low clock) and two ack slots
   function automatic slot_lines_type byte_slot(input logic [SLOT_W-1:0] b,
                                                input logic [7:0] value);
      slot_lines_type l;
      logic [2:0] bit_idx;
      l.rx = 1'b0;
      bit_idx = b[3:1];
      if (b < 7'd16) begin
         l.scl = ~b[0];
         l.sda = value[3'd7 - bit_idx];
      end else begin
         l.scl = (b == 7'd16);
         l.sda = 1'b1;
      end
      return l;
   endfunction

   assign read_device_address = 8'(device_address + 8'd1);

   always_comb begin
      lines = '{scl: 1'b1, sda: 1'b1, rx: 1'b0};
      if (slot < DEV_BYTE_START) begin
         lines.sda = (slot == '0);
      end else if (slot < REG_BYTE_START) begin
         lines = byte_slot(7'(slot - DEV_BYTE_START), device_address);
      end else if (slot < THIRD_PART_START) begin
         lines = byte_slot(7'(slot - REG_BYTE_START), register_address);
      end else if (!is_read) begin
         if (slot < WR_STOP_START) begin
            lines = byte_slot(7'(slot - THIRD_PART_START), write_data);
         end else begin
            lines.sda = (slot != WR_STOP_START);
         end
      end else begin
         if (slot < RD_ADDR_START) begin
            lines.sda = (slot == THIRD_PART_START);
         end else if (slot < RD_DATA_START) begin
            lines = byte_slot(7'(slot - RD_ADDR_START), read_device_address);
         end else if (slot < RD_NAK_HIGH) begin
            // data start is even, so the slot parity gives the clock phase
            lines.scl = slot[0];
            lines.rx  = slot[0];
         end else if (slot == RD_NAK_HIGH) begin
            lines.scl = 1'b1;
         end else if (slot == RD_NAK_LOW) begin
            lines.scl = 1'b0;
         end else begin
            lines.sda = (slot != RD_STOP_LOW);
         end
      end
   end

endmodule

[hdl/i2c_register_access_master.sv]
// top level of the single-register i2c read/write master
`timescale 1ns / 1ps

// Single-register I2C master stepped one bus slot per tick transfer. A command
// transfer (kind = 1) starts a register write (start, device address, register
// address, data, stop: 58 slots) or a register read (start, device address,
// register address, repeated start, device address plus one, eight data bits
// MSB first, NAK, stop: 78 slots). Every request transfer produces exactly one
// response transfer with the SCL/SDA levels of that slot, busy and done flags
// and the byte of the last completed read. Acknowledge bits are not checked,
// and a command that arrives during a transaction is dropped. Throughput is one
// transfer per clock while rsp_stall is low. Each transfer passes through the
// request register and then the response register, with the slot decode and
// state update in between. The request register fills while a response waits
// on rsp_stall, so up to two transfers are held before req_stall rises.
module i2c_register_access_master
   import i2cram_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic       req_read_not_write,
   input  logic [7:0] req_device_address,
   input  logic [7:0] req_register_address,
   input  logic [7:0] req_write_data,
   input  logic       req_sda_sample,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_data
);

`include "i2c_register_access_master_macros.svh"

   // request register
   logic       in_v_ff, in_v_in;
   logic       kind_ff, rnw_ff, sda_sample_ff;
   logic [7:0] dev_ff, regaddr_ff, wdata_ff;

   // transaction state
   logic              active_ff, active_in;
   logic              is_read_ff, is_read_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, slot_next;
   logic [7:0]        held_dev_ff, held_dev_in;
   logic [7:0]        held_reg_ff, held_reg_in;
   logic [7:0]        held_wdata_ff, held_wdata_in;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        read_hold_ff, read_hold_in;

   // response register
   logic       out_v_ff, out_v_in;
   logic       scl_ff, sda_ff, busy_ff, done_ff;
   logic       scl_in, sda_in, busy_in, done_in;

   logic              out_free;
   logic              advance;
   logic              take_req;
   logic [SLOT_W-1:0] total_slots;
   slot_lines_type    lines;

   // handshake: the response register frees when empty or being taken,
   // the request register moves on whenever the response side is free
   assign out_free  = !out_v_ff || !rsp_stall;
   assign advance   = in_v_ff && out_free;
   assign req_stall = in_v_ff && !out_free;
   assign take_req  = req_valid && !req_stall;
   assign in_v_in   = take_req || (in_v_ff && !out_free);
   assign out_v_in  = advance || (out_v_ff && rsp_stall);

   // slot decode from held transaction bytes
   i2cram_slot_decode u_slot_decode (
      .slot             (slot_ff),
      .is_read          (is_read_ff),
      .device_address   (held_dev_ff),
      .register_address (held_reg_ff),
      .write_data       (held_wdata_ff),
      .lines            (lines)
   );

   assign total_slots = is_read_ff ? READ_SLOTS : WRITE_SLOTS;
   assign slot_next   = 7'(slot_ff + 7'd1);

   // one item of work: command load, one bus slot, or an idle tick
   always_comb begin
      active_in     = active_ff;
      is_read_in    = is_read_ff;
      slot_in       = slot_ff;
      held_dev_in   = held_dev_ff;
      held_reg_in   = held_reg_ff;
      held_wdata_in = held_wdata_ff;
      shift_in      = shift_ff;
      read_hold_in  = read_hold_ff;
      scl_in        = 1'b1;
      sda_in        = 1'b1;
      busy_in       = 1'b0;
      done_in       = 1'b0;
      if (advance) begin
         if (kind_ff == KIND_CMD) begin
            // a command while busy is dropped; busy shows the state after it
            if (!active_ff) begin
               active_in     = 1'b1;
               is_read_in    = rnw_ff;
               held_dev_in   = dev_ff;
               held_reg_in   = regaddr_ff;
               held_wdata_in = wdata_ff;
               slot_in       = '0;
            end
            busy_in = 1'b1;
         end else if (active_ff) begin
            scl_in  = lines.scl;
            sda_in  = lines.sda;
            busy_in = 1'b1;
            if (lines.rx) begin
               shift_in = {shift_ff[6:0], sda_sample_ff};
            end
            slot_in = slot_next;
            if (slot_next >= total_slots) begin
               // last slot of the transaction
               active_in = 1'b0;
               slot_in   = '0;
               done_in   = 1'b1;
               if (is_read_ff) begin
                  read_hold_in = shift_in;
               end
            end
         end
      end
   end

   // control and transaction state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
         active_ff     <= 1'b0;
         is_read_ff    <= 1'b0;
         slot_ff       <= '0;
         held_dev_ff   <= '0;
         held_reg_ff   <= '0;
         held_wdata_ff <= '0;
         shift_ff      <= '0;
         read_hold_ff  <= '0;
      end else begin
         in_v_ff       <= in_v_in;
         out_v_ff      <= out_v_in;
         active_ff     <= active_in;
         is_read_ff    <= is_read_in;
         slot_ff       <= slot_in;
         held_dev_ff   <= held_dev_in;
         held_reg_ff   <= held_reg_in;
         held_wdata_ff <= held_wdata_in;
         shift_ff      <= shift_in;
         read_hold_ff  <= read_hold_in;
      end
   end

   // request payload register
   always_ff @(posedge clock) begin
      if (take_req) begin
         kind_ff       <= req_kind;
         rnw_ff        <= req_read_not_write;
         dev_ff        <= req_device_address;
         regaddr_ff    <= req_register_address;
         wdata_ff      <= req_write_data;
         sda_sample_ff <= req_sda_sample;
      end
   end

   // response payload register
   logic [7:0] rdata_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         rdata_ff <= read_hold_in;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_data = rdata_ff;

   // checks on the sequencer
   `I2CRAM_ASSERT_NOW(a_slot_in_range, active_ff, slot_ff < total_slots, "slot past end")
   `I2CRAM_ASSERT_NOW(a_idle_slot_zero, !active_ff, slot_ff == '0, "idle with slot set")
   `I2CRAM_ASSERT_NEXT(a_done_ends, advance && done_in, !active_ff, "active after done")
   `I2CRAM_ASSERT_NOW(a_done_busy, out_v_ff && done_ff, busy_ff, "done without busy")

endmodule
